// File: rtl/core/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, sizes and helper functions for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int OFF_W  = 8;
  localparam int STAT_W = 2;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = ADDR_W + 1;
  // index sum wide enough for pointer + offset without overflow
  localparam int IDX_W  = ((ADDR_W > OFF_W) ? ADDR_W : OFF_W) + 1;

  typedef logic [ADDR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;   // capture the request fields
    logic exec;   // perform the operation and update state
  } deq_cmd_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_inc = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    ptr_dec = (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
  endfunction

endpackage

// File: rtl/core/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Fixed-capacity double-ended queue over a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive kind/value/offset and raise start. The request is
//   taken at a rising edge with start high and busy low. kind selects push
//   front, push back, pop front, pop back or read at offset from the front.
//   Result channel: done is high for exactly one cycle with data, status and
//   count valid; the result transfer completes at the edge ending that cycle.
//   The receiver cannot stall, so results are never held back.
// Timing:
//   Accept edge -> execute cycle (one store access, pointer/count update) ->
//   result cycle. done is high in the result cycle (state S_DONE, after S_EXEC).
//   busy stays high through both, so no new request is taken until the result
//   cycle is over; the sequencer's three states set that limit.
// Errors:
//   Push onto a full queue, pop from an empty one and a read at or past the
//   count are refused: status flags the cause, data is zero, state unchanged.
// Reset:
//   rst (synchronous) empties the queue and returns to idle. The store keeps
//   no reset; entries are only read after being written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic [OFF_W-1:0]         offset,
  output logic                     done,
  output logic signed [DATA_W-1:0] data,
  output logic [STAT_W-1:0]        status,
  output logic [CNT_W-1:0]         count
);

  deq_cmd_t cmd;

  // sequencer: idle -> exec -> done
  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // store, pointers, count and result registers
  deq_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .kind   (kind),
    .value  (value),
    .offset (offset),
    .data   (data),
    .status (status),
    .count  (count)
  );

endmodule

// File: rtl/core/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: accept, execute, present result.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  output deq_cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted request did not enter execution");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> done)
    else $error("execution not followed by result");

endmodule

// File: rtl/core/deq_dpath.sv
// ----------------------------------------------------------------------------
// deq_dpath
// Ring store, front/back pointers, element count and result registers.
// ----------------------------------------------------------------------------
module deq_dpath
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  deq_cmd_t                 cmd,
  input  logic [KIND_W-1:0]        kind,
  input  logic signed [DATA_W-1:0] value,
  input  logic [OFF_W-1:0]         offset,
  output logic signed [DATA_W-1:0] data,
  output logic [STAT_W-1:0]        status,
  output logic [CNT_W-1:0]         count
);

  logic [DATA_W-1:0] mem [DEPTH];

  // captured request
  logic [KIND_W-1:0] kind_q;
  logic [DATA_W-1:0] value_q;
  logic [OFF_W-1:0]  off_q;

  // queue state
  ptr_t front, front_next;
  ptr_t back, back_next;
  cnt_t fill, fill_next;

  // result
  status_t           stat_q, stat_next;
  logic              rd_op_q, rd_op_next;
  logic [DATA_W-1:0] rd_q;

  ptr_t             addr;
  logic             wr_en;
  logic [IDX_W-1:0] idx_sum;
  logic             full, empty, in_range;

  assign full     = (fill == cnt_t'(DEPTH));
  assign empty    = (fill == '0);
  assign in_range = (IDX_W'(off_q) < IDX_W'(fill));

  always_comb begin
    idx_sum = IDX_W'(front) + IDX_W'(off_q);
    if (idx_sum >= IDX_W'(DEPTH)) begin
      idx_sum = idx_sum - IDX_W'(DEPTH);
    end
  end

  always_comb begin
    front_next = front;
    back_next  = back;
    fill_next  = fill;
    stat_next  = STAT_OK;
    rd_op_next = 1'b0;
    wr_en      = 1'b0;
    addr       = front;
    unique case (kind_t'(kind_q))
      KIND_PUSH_FRONT: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          front_next = ptr_dec(front);
          addr       = front_next;
          wr_en      = 1'b1;
          fill_next  = fill + cnt_t'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          stat_next = STAT_FULL;
        end else begin
          addr      = back;
          back_next = ptr_inc(back);
          wr_en     = 1'b1;
          fill_next = fill + cnt_t'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          addr       = front;
          front_next = ptr_inc(front);
          rd_op_next = 1'b1;
          fill_next  = fill - cnt_t'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          stat_next = STAT_EMPTY;
        end else begin
          back_next  = ptr_dec(back);
          addr       = back_next;
          rd_op_next = 1'b1;
          fill_next  = fill - cnt_t'(1);
        end
      end
      KIND_READ: begin
        if (!in_range) begin
          stat_next = STAT_RANGE;
        end else begin
          addr       = idx_sum[ADDR_W-1:0];
          rd_op_next = 1'b1;
        end
      end
      default: begin
        // unused kinds: no effect
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q  <= kind;
      value_q <= value;
      off_q   <= offset;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[addr] <= value_q;
    end
    if (cmd.exec) begin
      rd_q <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front   <= '0;
      back    <= '0;
      fill    <= '0;
      stat_q  <= STAT_OK;
      rd_op_q <= 1'b0;
    end else if (cmd.exec) begin
      front   <= front_next;
      back    <= back_next;
      fill    <= fill_next;
      stat_q  <= stat_next;
      rd_op_q <= rd_op_next;
    end
  end

  assign data   = rd_op_q ? rd_q : '0;
  assign status = stat_q;
  assign count  = fill;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= cnt_t'(DEPTH))
    else $error("element count exceeds capacity");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (front == back))
    else $error("pointers disagree with empty/full count");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && stat_next != STAT_OK) |=>
      ($stable(fill) && $stable(front) && $stable(back)))
    else $error("refused operation changed queue state");

endmodule
